// ===== design/css_pkg.sv =====
package css_pkg;

  // Accumulator and fixed-point widths
  localparam int ACC_W   = 48;
  localparam int MUL_W   = 33;
  localparam int CFG_IDX_W = 2;
  localparam int EXP_K   = 16;
  localparam int EXP_CW  = 30;
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // Element width, signed Q4.12; sized to fit the shared multiplier
  localparam int ELEMENT_WIDTH = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TEMP  = 2'd2;

  // Integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // exp2 constants c_k = 2^-(2^-k) in Q0.30, k = 1..16, entry k-1
  function automatic logic [EXP_K*EXP_CW-1:0] build_exp_table();
    logic [EXP_K*EXP_CW-1:0] t;
    logic [63:0] c;
    t = '0;
    c = 64'd1 << 29;
    for (int k = 1; k <= EXP_K; k++) begin
      c = isqrt_c(c << 30);
      t[(k-1)*EXP_CW +: EXP_CW] = c[EXP_CW-1:0];
    end
    return t;
  endfunction

  localparam logic [EXP_K*EXP_CW-1:0] EXP_TABLE = build_exp_table();

endpackage

// ===== design/css_in_if.sv =====
interface css_in_if
  import css_pkg::*;
();
  logic                            valid;
  logic                            ready;
  logic signed [ELEMENT_WIDTH-1:0] query_element;
  logic signed [ELEMENT_WIDTH-1:0] candidate_element;
  logic                            last_element;
  logic [7:0]                      usage_count;

  modport source (output valid, query_element, candidate_element, last_element, usage_count,
                  input ready);
  modport sink (input valid, query_element, candidate_element, last_element, usage_count,
                output ready);
endinterface

// ===== design/css_out_if.sv =====
interface css_out_if ();
  logic        valid;
  logic        ready;
  logic [15:0] score;
  logic        zero_norm;
  logic        below_threshold;

  modport source (output valid, score, zero_norm, below_threshold, input ready);
  modport sink (input valid, score, zero_norm, below_threshold, output ready);
endinterface

// ===== design/css_cfg_if.sv =====
interface css_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/cosine_similarity_scorer.sv =====
// Cosine similarity scorer.
// Channel elements: one word per element pair (query, candidate, last flag,
// usage count). Channel scores: one word per vector, given after the pair
// marked last: score (Q1.15), zero_norm, below_threshold.
// Channel cfg: register writes (0 threshold, 1 penalty, 2 inverse
// temperature); always ready, write only while idle.
// Element pairs: each pair is accepted, then takes three products through
// the single shared multiplier and the final accumulate; a new pair is not
// taken before the last is through: elements is ready only while the sequencer is idle.
// The last pair adds the score computation: two 24-step square roots, one
// 62-step restoring division, then with scaling enabled up to 15
// normalize steps, 16 squaring steps and up to 16 exp2 multiply steps.
// The result sits in an output register; a new vector's elements are taken
// while it waits. If the receiver stalls, the next result holds in the
// sequencer until the output register frees.
// Reset (rst, synchronous) clears the configuration registers to zero, clears the
// accumulators and empties the output register.
module cosine_similarity_scorer
  import css_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  css_in_if.sink    elements,
  css_out_if.source scores,
  css_cfg_if.sink   cfg
);

  typedef enum logic [4:0] {
    S_IDLE, S_MQC, S_MQQ, S_MCC, S_ACC, S_CHK, S_SQA, S_SQB, S_DEN, S_DVI, S_DIV,
    S_COS, S_PEN, S_NRM, S_LGM, S_LGA, S_PWM, S_PWA, S_EXM, S_EXA, S_SHF, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [15:0] thr, pen_cfg, inv_t;

  // element registers
  logic signed [ELEMENT_WIDTH-1:0] q, c;
  logic        last_r;
  logic [7:0]  usage;

  // accumulators
  logic [ACC_W-1:0] dot, qn, cn;

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_full;
  logic [63:0]               prod;

  // sqrt / divide working registers
  logic [ACC_W-1:0] sx, sr, sbit;
  logic [23:0]      ra, rb;
  logic [ACC_W-1:0] den, rem;
  logic [61:0]      nsh;
  logic [16:0]      quo;
  logic             sat;
  logic [5:0]       cnt;
  logic [15:0]      cosr;

  // power working registers
  logic [16:0] px;
  logic [3:0]  pn;
  logic [15:0] pf;
  logic [3:0]  ip;
  logic [15:0] fp;
  logic [30:0] y;
  logic [4:0]  k;

  // result
  logic [15:0] res_score;
  logic        res_zn, res_bt;
  logic        ov;
  logic [15:0] o_score;
  logic        o_zn, o_bt;

  logic in_acc;
  assign in_acc = elements.valid && elements.ready;
  assign elements.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign scores.valid = ov;
  assign scores.score = o_score;
  assign scores.zero_norm = o_zn;
  assign scores.below_threshold = o_bt;

  // output register load
  logic out_load;
  assign out_load = (state == S_DONE) && (!ov || scores.ready);

  // exp2 constant for step k
  logic [EXP_CW-1:0] ck;
  assign ck = EXP_TABLE[32'(4'(k - 5'd1)) * EXP_CW +: EXP_CW];

  logic [19:0] lmag;
  assign lmag = {pn, 16'b0} - 20'(pf);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MQC: begin
        mul_a = MUL_W'(q);
        mul_b = MUL_W'(c);
      end
      S_MQQ: begin
        mul_a = MUL_W'(q);
        mul_b = MUL_W'(q);
      end
      S_MCC: begin
        mul_a = MUL_W'(c);
        mul_b = MUL_W'(c);
      end
      S_DEN: begin
        mul_a = MUL_W'(ra);
        mul_b = MUL_W'(rb);
      end
      S_COS: begin
        mul_a = MUL_W'(usage);
        mul_b = MUL_W'(pen_cfg);
      end
      S_LGM: begin
        mul_a = MUL_W'(px);
        mul_b = MUL_W'(px);
      end
      S_PWM: begin
        mul_a = MUL_W'(lmag);
        mul_b = MUL_W'(inv_t);
      end
      S_EXM: begin
        mul_a = MUL_W'(y);
        mul_b = MUL_W'(ck);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_full = mul_a * mul_b;

  // square root step
  logic [ACC_W-1:0] st, sx_next, sr_next;
  logic             sge;
  always_comb begin
    st = sr + sbit;
    sge = (sx >= st);
    sx_next = sge ? sx - st : sx;
    sr_next = sge ? (sr >> 1) + sbit : (sr >> 1);
  end

  // division step
  logic [ACC_W:0]   rem_sh;
  logic             dge;
  logic [ACC_W-1:0] rem_next;
  logic [16:0]      quo_next;
  always_comb begin
    rem_sh = {rem, nsh[61]};
    dge = (rem_sh >= {1'b0, den});
    rem_next = dge ? ACC_W'(rem_sh - {1'b0, den}) : rem_sh[ACC_W-1:0];
    quo_next = {quo[15:0], dge};
  end

  logic [15:0] cos_w;
  assign cos_w = (sat || (quo > 17'(ONE_Q15))) ? ONE_Q15 : quo[15:0];

  // penalty and log step helpers
  logic [23:0] pen_prod;
  logic [15:0] sc_pen;
  logic [17:0] lt;
  logic [27:0] pw;
  logic [4:0]  sh;
  logic [30:0] ys;
  assign pen_prod = prod[23:0];
  assign sc_pen = (24'(cosr) > pen_prod) ? cosr - pen_prod[15:0] : 16'd0;
  assign lt = prod[32:15];
  assign pw = prod[35:8];
  assign sh = 5'd15 + {1'b0, ip};
  assign ys = y >> sh;

  // sequencer
  always_ff @(posedge clk) begin
    prod <= mul_full[63:0];
    if (rst) begin
      state <= S_IDLE;
      thr <= '0;
      pen_cfg <= '0;
      inv_t <= '0;
      dot <= '0;
      qn <= '0;
      cn <= '0;
      ov <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_THRESHOLD: thr <= cfg.data;
          CFG_PENALTY:   pen_cfg <= cfg.data;
          CFG_INV_TEMP:  inv_t <= cfg.data;
          default: ;
        endcase
      end
      if (out_load) begin
        ov <= 1'b1;
      end else if (ov && scores.ready) begin
        ov <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            q <= elements.query_element;
            c <= elements.candidate_element;
            last_r <= elements.last_element;
            usage <= elements.usage_count;
            state <= S_MQC;
          end
        end
        S_MQC: state <= S_MQQ;
        S_MQQ: begin
          dot <= dot + prod[ACC_W-1:0];
          state <= S_MCC;
        end
        S_MCC: begin
          qn <= qn + prod[ACC_W-1:0];
          state <= S_ACC;
        end
        S_ACC: begin
          cn <= cn + prod[ACC_W-1:0];
          state <= last_r ? S_CHK : S_IDLE;
        end
        S_CHK: begin
          res_score <= '0;
          res_zn <= 1'b0;
          res_bt <= 1'b0;
          if (qn == '0 || cn == '0) begin
            res_zn <= 1'b1;
            state <= S_DONE;
          end else begin
            sx <= qn;
            sr <= '0;
            sbit <= ACC_W'(1) << (ACC_W - 2);
            cnt <= 6'd24;
            state <= S_SQA;
          end
        end
        S_SQA: begin
          sx <= sx_next;
          sr <= sr_next;
          sbit <= sbit >> 2;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            ra <= sr_next[23:0];
            sx <= cn;
            sr <= '0;
            sbit <= ACC_W'(1) << (ACC_W - 2);
            cnt <= 6'd24;
            state <= S_SQB;
          end
        end
        S_SQB: begin
          sx <= sx_next;
          sr <= sr_next;
          sbit <= sbit >> 2;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            rb <= sr_next[23:0];
            state <= S_DEN;
          end
        end
        S_DEN: state <= S_DVI;
        S_DVI: begin
          den <= prod[ACC_W-1:0];
          rem <= '0;
          quo <= '0;
          sat <= 1'b0;
          nsh <= {dot[ACC_W-2:0], 15'b0};
          cnt <= 6'd62;
          state <= (dot[ACC_W-1] || dot == '0) ? S_COS : S_DIV;
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          sat <= sat | quo[16];
          nsh <= nsh << 1;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= S_COS;
        end
        S_COS: begin
          if (dot[ACC_W-1] || cos_w < thr) begin
            res_bt <= 1'b1;
            state <= S_DONE;
          end else begin
            cosr <= cos_w;
            state <= S_PEN;
          end
        end
        S_PEN: begin
          res_score <= sc_pen;
          px <= 17'(sc_pen);
          pn <= '0;
          state <= (inv_t == '0 || sc_pen == '0) ? S_DONE : S_NRM;
        end
        S_NRM: begin
          if (px[16:15] == 2'b00) begin
            px <= px << 1;
            pn <= pn + 4'd1;
          end else begin
            pf <= '0;
            cnt <= 6'd16;
            state <= S_LGM;
          end
        end
        S_LGM: state <= S_LGA;
        S_LGA: begin
          pf <= {pf[14:0], lt[16]};
          px <= lt[16] ? lt[17:1] : lt[16:0];
          cnt <= cnt - 6'd1;
          state <= (cnt == 6'd1) ? S_PWM : S_LGM;
        end
        S_PWM: state <= S_PWA;
        S_PWA: begin
          ip <= pw[19:16];
          fp <= pw[15:0];
          y <= 31'd1 << 30;
          k <= 5'd1;
          if (pw[27:20] != '0) begin
            res_score <= '0;
            state <= S_DONE;
          end else begin
            state <= S_EXM;
          end
        end
        S_EXM: begin
          priority if (k == 5'd17) begin
            state <= S_SHF;
          end else if (fp[4'(5'd16 - k)]) begin
            state <= S_EXA;
          end else begin
            k <= k + 5'd1;
          end
        end
        S_EXA: begin
          y <= prod[60:30];
          k <= k + 5'd1;
          state <= S_EXM;
        end
        S_SHF: begin
          res_score <= (ys > 31'(ONE_Q15)) ? ONE_Q15 : ys[15:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            o_score <= res_score;
            o_zn <= res_zn;
            o_bt <= res_bt;
            dot <= '0;
            qn <= '0;
            cn <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    scores.valid |-> !(scores.zero_norm && scores.below_threshold))
    else $error("zero_norm and below_threshold both set");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (scores.valid && (scores.zero_norm || scores.below_threshold)) |-> scores.score == '0)
    else $error("flagged result with nonzero score");

  a_score_max: assert property (@(posedge clk) disable iff (rst)
    scores.valid |-> scores.score <= ONE_Q15)
    else $error("score above one");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !elements.ready)
    else $error("ready while element in flight");

endmodule
